[rtl/lfsf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package lfsf_pkg;

  // defaults for the top level parameters
  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  // fixed field widths
  localparam int CFG_W     = 11;
  localparam int SIDE_W    = 11;
  localparam int ROW_OUT_W = 10;
  localparam int COL_OUT_W = 10;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 32;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 11'd1024;

  // register word index (paddr[2])
  localparam logic REG_ROW_WIDTH = 1'b0;

  // per-cell control flags that travel from the scan counters into the dp stage
  typedef struct packed {
    logic last;
    logic first_row;
    logic col_zero;
    logic overflow;
  } lfsf_tag_t;

endpackage
`default_nettype wire

[rtl/lfsf_line_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
module lfsf_line_mem #(
  parameter int DEPTH = lfsf_pkg::MAX_COLS_DEF,
  parameter int WIDTH = lfsf_pkg::SIDE_W
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/lfsf_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
module lfsf_scan #(
  parameter int MAX_COLS = lfsf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lfsf_pkg::MAX_ROWS_DEF,
  localparam int CW = $clog2(MAX_COLS),
  localparam int RW = $clog2(MAX_ROWS)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic                       last,
  input  wire logic [lfsf_pkg::CFG_W-1:0] row_width,
  output logic      [CW-1:0]              col_r,
  output logic      [RW-1:0]              row_r,
  output logic                            first_row_r,
  output logic                            overflow_r
);

  localparam int CMPW = (CW + 1 > lfsf_pkg::CFG_W) ? CW + 1 : lfsf_pkg::CFG_W;

  logic [CW:0] col_inc;
  logic        wrap;

  assign col_inc = {1'b0, col_r} + 1'b1;
  // a width of zero wraps every cell, like a width of one
  assign wrap = (CMPW'(col_inc) >= CMPW'(row_width)) ||
                (CMPW'(col_inc) >= CMPW'(MAX_COLS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      first_row_r <= 1'b1;
      overflow_r  <= 1'b0;
    end else if (accept) begin
      if (last) begin
        col_r       <= '0;
        row_r       <= '0;
        first_row_r <= 1'b1;
        overflow_r  <= 1'b0;
      end else if (wrap) begin
        col_r       <= '0;
        first_row_r <= 1'b0;
        if (row_r >= RW'(MAX_ROWS - 1)) begin
          overflow_r <= 1'b1;
        end else begin
          row_r <= row_r + 1'b1;
        end
      end else begin
        col_r <= col_inc[CW-1:0];
      end
    end
  end

endmodule
`default_nettype wire

[rtl/lfsf_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module lfsf_dp #(
  parameter int MAX_COLS = lfsf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lfsf_pkg::MAX_ROWS_DEF,
  localparam int CW = $clog2(MAX_COLS),
  localparam int RW = $clog2(MAX_ROWS),
  localparam int SW = $clog2(MAX_COLS + 1)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // scan side
  input  wire logic                           s0_fire,
  input  wire logic                           s0_free,
  input  wire logic [CW-1:0]                  s0_col,
  input  wire logic [RW-1:0]                  s0_row,
  input  wire lfsf_pkg::lfsf_tag_t            s0_tag,
  output logic                                stall,
  // line store
  input  wire logic [SW-1:0]                  mem_rd_data,
  output logic                                mem_wr_en,
  output logic      [CW-1:0]                  mem_wr_addr,
  output logic      [SW-1:0]                  mem_wr_data,
  // result
  output logic                                out_valid_r,
  input  wire logic                           out_ready,
  output logic      [lfsf_pkg::SIDE_W-1:0]    out_side_r,
  output logic      [lfsf_pkg::ROW_OUT_W-1:0] out_row_r,
  output logic      [lfsf_pkg::COL_OUT_W-1:0] out_col_r,
  output logic                                out_ovf_r
);

  logic                s1_valid_r;
  logic                s1_free_r;
  logic [CW-1:0]       s1_col_r;
  logic [RW-1:0]       s1_row_r;
  lfsf_pkg::lfsf_tag_t s1_tag_r;
  logic                s1_fwd_r;
  logic [SW-1:0]       s1_fwd_data_r;

  logic [SW-1:0] left_r;
  logic [SW-1:0] diag_r;
  logic [SW-1:0] best_size_r;
  logic [RW-1:0] best_row_r;
  logic [CW-1:0] best_col_r;

  logic [SW-1:0] up;
  logic [SW-1:0] left;
  logic [SW-1:0] diag;
  logic [SW-1:0] m2;
  logic [SW-1:0] m3;
  logic [SW-1:0] size;
  logic          s1_fire;
  logic          better;
  logic          load_out;

  always_comb begin
    if (s1_tag_r.first_row) begin
      up = '0;
    end else if (s1_fwd_r) begin
      up = s1_fwd_data_r;
    end else begin
      up = mem_rd_data;
    end
    left = s1_tag_r.col_zero ? '0 : left_r;
    diag = (s1_tag_r.col_zero || s1_tag_r.first_row) ? '0 : diag_r;
    m2   = (up < left) ? up : left;
    m3   = (m2 < diag) ? m2 : diag;
    size = s1_free_r ? SW'(m3 + 1'b1) : '0;
  end

  assign stall    = s1_valid_r && s1_tag_r.last && out_valid_r && !out_ready;
  assign s1_fire  = s1_valid_r && !stall;
  assign better   = !s1_tag_r.overflow && (size > best_size_r);
  assign load_out = s1_fire && s1_tag_r.last;

  assign mem_wr_en   = s1_fire;
  assign mem_wr_addr = s1_col_r;
  assign mem_wr_data = size;

  // stage 1 register, with a bypass for a read of the column being written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s0_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_fire) begin
      s1_free_r     <= s0_free;
      s1_col_r      <= s0_col;
      s1_row_r      <= s0_row;
      s1_tag_r      <= s0_tag;
      s1_fwd_r      <= s1_fire && (s1_col_r == s0_col);
      s1_fwd_data_r <= size;
    end
  end

  // neighbor sizes and best tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= '0;
      diag_r      <= '0;
      best_size_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
    end else if (s1_fire) begin
      if (s1_tag_r.last) begin
        left_r      <= '0;
        diag_r      <= '0;
        best_size_r <= '0;
        best_row_r  <= '0;
        best_col_r  <= '0;
      end else begin
        left_r <= size;
        diag_r <= up;
        if (better) begin
          best_size_r <= size;
          best_row_r  <= s1_row_r;
          best_col_r  <= s1_col_r;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ovf_r <= s1_tag_r.overflow;
      if (better) begin
        out_side_r <= lfsf_pkg::SIDE_W'(size);
        out_row_r  <= lfsf_pkg::ROW_OUT_W'(s1_row_r);
        out_col_r  <= lfsf_pkg::COL_OUT_W'(s1_col_r);
      end else begin
        out_side_r <= lfsf_pkg::SIDE_W'(best_size_r);
        out_row_r  <= lfsf_pkg::ROW_OUT_W'(best_row_r);
        out_col_r  <= lfsf_pkg::COL_OUT_W'(best_col_r);
      end
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over a waiting beat");

  a_no_accept_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s0_fire |-> !stall)
    else $error("cell accepted while dp stage stalled");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> (s1_valid_r && $stable(s1_col_r)))
    else $error("stalled cell lost");

  a_best_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !s1_tag_r.last) |=> (best_size_r >= $past(best_size_r)))
    else $error("best size shrank within a grid");

  a_grid_end: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (out_valid_r && best_size_r == '0))
    else $error("grid end did not clear best");

endmodule
`default_nettype wire

[rtl/largest_free_square_finder.sv]
`timescale 1ns / 1ps
`default_nettype none
// Largest free square finder. Cells of a binary grid arrive one beat each in
// row-major order (tdata bit 0 = free, tlast = final cell). A new beat is
// accepted each clock, and the input waits only while a final cell cannot
// hand its result over because the previous result beat is still not taken.
// After the final cell is accepted, it passes the stage 1 register and then
// loads the result register, which drives the one result beat. The result
// gives the side of the largest free square and its bottom-right corner
// (first in scan order on a tie), plus a flag when the grid had more than
// MAX_ROWS rows. The line store holding the previous row needs no clearing
// after reset. row_width (APB offset 0) may be written only while the block
// is idle; 0 acts as 1 and values above MAX_COLS act as MAX_COLS.
module largest_free_square_finder #(
  parameter int MAX_COLS = lfsf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lfsf_pkg::MAX_ROWS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // cell beats
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [lfsf_pkg::IN_DATA_W-1:0]   in_tdata,   // [0] cell_free, rest zero
  input  wire logic                             in_tlast,   // last_cell
  // result beats
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [10:0] square_side, [20:11] corner_row, [30:21] corner_col, [31] too_many_rows
  output logic      [lfsf_pkg::OUT_DATA_W-1:0]  out_tdata,
  // configuration
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [lfsf_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [lfsf_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic      [lfsf_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int SW = $clog2(MAX_COLS + 1);

  logic [lfsf_pkg::CFG_W-1:0] row_width_r;

  logic                       s0_fire;
  logic                       stall;
  logic [CW-1:0]              col;
  logic [RW-1:0]              row;
  logic                       first_row;
  logic                       overflow;
  lfsf_pkg::lfsf_tag_t        tag;

  logic [SW-1:0]              mem_rd_data;
  logic                       mem_wr_en;
  logic [CW-1:0]              mem_wr_addr;
  logic [SW-1:0]              mem_wr_data;

  logic [lfsf_pkg::SIDE_W-1:0]    out_side;
  logic [lfsf_pkg::ROW_OUT_W-1:0] out_row;
  logic [lfsf_pkg::COL_OUT_W-1:0] out_col;
  logic                           out_ovf;

  // register port: always ready, write on the access phase
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= lfsf_pkg::ROW_WIDTH_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == lfsf_pkg::REG_ROW_WIDTH) begin
      row_width_r <= cfg_pwdata[lfsf_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      lfsf_pkg::REG_ROW_WIDTH: cfg_prdata = lfsf_pkg::APB_DATA_W'(row_width_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // input side only waits when a final cell is blocked by an untaken result
  assign in_tready = !stall;
  assign s0_fire   = in_tvalid && in_tready;

  // column/row position of the cell being accepted
  lfsf_scan #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (s0_fire),
    .last        (in_tlast),
    .row_width   (row_width_r),
    .col_r       (col),
    .row_r       (row),
    .first_row_r (first_row),
    .overflow_r  (overflow)
  );

  // last, first_row, col_zero, overflow from the top bit down
  assign tag = {in_tlast, first_row, (col == '0), overflow};

  // previous row sizes, read on accept and written back when the cell leaves stage 1
  lfsf_line_mem #(
    .DEPTH (MAX_COLS),
    .WIDTH (SW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (s0_fire),
    .rd_addr (col),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // three-way min, best tracking and result register
  lfsf_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .s0_fire     (s0_fire),
    .s0_free     (in_tdata[0]),
    .s0_col      (col),
    .s0_row      (row),
    .s0_tag      (tag),
    .stall       (stall),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .out_valid_r (out_tvalid),
    .out_ready   (out_tready),
    .out_side_r  (out_side),
    .out_row_r   (out_row),
    .out_col_r   (out_col),
    .out_ovf_r   (out_ovf)
  );

  assign out_tdata = {out_ovf, out_col, out_row, out_side};

endmodule
`default_nettype wire

[dv/lfsf_square_checker.sv]
`timescale 1ns / 1ps
module lfsf_square_checker #(
  parameter int MAX_COLS = lfsf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = lfsf_pkg::MAX_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [lfsf_pkg::IN_DATA_W-1:0]    in_tdata,   // [0] cell_free, rest zero
  input  logic                              in_tlast,   // last_cell
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  // [10:0] square_side, [20:11] corner_row, [30:21] corner_col, [31] too_many_rows
  input  logic [lfsf_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lfsf_pkg::APB_ADDR_W-1:0]   cfg_paddr,
  input  logic [lfsf_pkg::APB_DATA_W-1:0]   cfg_pwdata,
  input  logic [lfsf_pkg::APB_DATA_W-1:0]   cfg_prdata,
  input  logic                              cfg_pready,
  output int                                fail_count,
  output int                                due_count
);

  typedef struct {
    logic [lfsf_pkg::SIDE_W-1:0]    side;
    logic [lfsf_pkg::ROW_OUT_W-1:0] row;
    logic [lfsf_pkg::COL_OUT_W-1:0] col;
    logic                           too_many;
  } square_t;

  square_t                     squares_due [$];
  logic [lfsf_pkg::SIDE_W-1:0] upper_sizes [MAX_COLS];
  logic [lfsf_pkg::CFG_W-1:0]  row_width;
  logic                        on_first_row;
  logic [lfsf_pkg::SIDE_W-1:0] left_sz;
  logic [lfsf_pkg::SIDE_W-1:0] diag_sz;
  int                          col_idx;
  int                          row_idx;
  logic [lfsf_pkg::SIDE_W-1:0] best_side;
  int                          best_row;
  int                          best_col;
  logic                        rows_overflowed;
  int                          fails = 0;

  initial begin
    fail_count = 0;
    due_count  = 0;
  end

  task automatic restart_grid();
    on_first_row    = 1'b1;
    left_sz         = '0;
    diag_sz         = '0;
    col_idx         = 0;
    row_idx         = 0;
    best_side       = '0;
    best_row        = 0;
    best_col        = 0;
    rows_overflowed = 1'b0;
  endtask

  task automatic note_fail(input string msg);
    fails++;
    if (fails <= 10) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // one cell of the dp scan; queues the grid result on the last cell
  task automatic scan_cell(input logic free, input logic last);
    int                          width;
    logic [lfsf_pkg::SIDE_W-1:0] up;
    logic [lfsf_pkg::SIDE_W-1:0] left;
    logic [lfsf_pkg::SIDE_W-1:0] diag;
    logic [lfsf_pkg::SIDE_W-1:0] least;
    logic [lfsf_pkg::SIDE_W-1:0] size;
    square_t                     res;
    width = (row_width == 0) ? 1 : (row_width > MAX_COLS) ? MAX_COLS : int'(row_width);
    up    = (on_first_row || col_idx >= MAX_COLS) ? '0 : upper_sizes[col_idx];
    left  = (col_idx == 0) ? '0 : left_sz;
    diag  = (col_idx == 0 || on_first_row) ? '0 : diag_sz;
    least = (up < left) ? up : left;
    if (diag < least) least = diag;
    size = free ? least + 1'b1 : '0;
    diag_sz = up;
    left_sz = size;
    if (col_idx < MAX_COLS) upper_sizes[col_idx] = size;
    if (!rows_overflowed && size > best_side) begin
      best_side = size;
      best_row  = row_idx;
      best_col  = col_idx;
    end
    if (last) begin
      res.side     = best_side;
      res.row      = lfsf_pkg::ROW_OUT_W'(best_row);
      res.col      = lfsf_pkg::COL_OUT_W'(best_col);
      res.too_many = rows_overflowed;
      squares_due.push_back(res);
      restart_grid();
    end else begin
      col_idx++;
      if (col_idx >= width) begin
        col_idx      = 0;
        on_first_row = 1'b0;
        if (row_idx >= MAX_ROWS - 1) rows_overflowed = 1'b1;
        else row_idx++;
      end
    end
  endtask

  always @(posedge clk) begin
    square_t                        want;
    logic [lfsf_pkg::SIDE_W-1:0]    got_side;
    logic [lfsf_pkg::ROW_OUT_W-1:0] got_row;
    logic [lfsf_pkg::COL_OUT_W-1:0] got_col;
    logic                           got_too_many;
    if (!rst_n) begin
      row_width = lfsf_pkg::ROW_WIDTH_RST;
      restart_grid();
      squares_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr[2] == lfsf_pkg::REG_ROW_WIDTH)
            row_width = cfg_pwdata[lfsf_pkg::CFG_W-1:0];
        end else if (cfg_paddr[2] == lfsf_pkg::REG_ROW_WIDTH &&
                     cfg_prdata !== lfsf_pkg::APB_DATA_W'(row_width)) begin
          note_fail($sformatf("row_width read expected %0d got %0h", row_width, cfg_prdata));
        end
      end
      if (in_tvalid && in_tready) scan_cell(in_tdata[0], in_tlast);
      if (out_tvalid && out_tready) begin
        got_side     = out_tdata[10:0];
        got_row      = out_tdata[20:11];
        got_col      = out_tdata[30:21];
        got_too_many = out_tdata[31];
        if (squares_due.size() == 0) begin
          note_fail($sformatf("result beat %0h with no grid pending", out_tdata));
        end else begin
          want = squares_due.pop_front();
          if (got_side !== want.side || got_row !== want.row ||
              got_col !== want.col || got_too_many !== want.too_many) begin
            note_fail($sformatf(
              "side %0d/%0d row %0d/%0d col %0d/%0d overflow %0d/%0d (expected/actual)",
              want.side, got_side, want.row, got_row, want.col, got_col,
              want.too_many, got_too_many));
          end
        end
      end
    end
    fail_count <= fails;
    due_count  <= squares_due.size();
  end

endmodule

[dv/largest_free_square_finder_tb.sv]
`timescale 1ns / 1ps
module largest_free_square_finder_tb;

  // register addresses: row_width and the unmapped word beside it
  localparam logic [lfsf_pkg::APB_ADDR_W-1:0] ROW_WIDTH_ADDR = 3'd0;
  localparam logic [lfsf_pkg::APB_ADDR_W-1:0] SPARE_ADDR     = 3'd4;

  localparam int RAND_CELLS  = 600;     // cells in the random part
  localparam int RAND_GRIDS  = 20;      // and at least this many random grids
  localparam int SETTLE      = 4;       // extra wait in wait_idle for the pipe to drain
  localparam int CYCLE_LIMIT = 300000;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [lfsf_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                            in_tlast;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [lfsf_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [lfsf_pkg::APB_ADDR_W-1:0] cfg_paddr;
  logic [lfsf_pkg::APB_DATA_W-1:0] cfg_pwdata;
  logic [lfsf_pkg::APB_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  int fail_count;
  int due_count;

  // sender burst state and run statistics
  int burst_left   = 0;
  int eff_width    = lfsf_pkg::MAX_COLS_DEF;
  int cells_sent   = 0;
  int grids_sent   = 0;
  int width_writes = 0;
  int rand_cells   = 0;
  int rand_grids   = 0;
  int cycle_count  = 0;

  // receiver stall pattern: segments of always-ready, coin-flip and sparse-ready
  int stall_mode  = 0;
  int stall_len   = 0;
  int stall_phase = 0;

  always #4 clk = ~clk;

  largest_free_square_finder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  lfsf_square_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .due_count   (due_count)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_len == 0) begin
      stall_mode  = $urandom_range(0, 2);
      stall_len   = $urandom_range(1, 60);
      stall_phase = 0;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= $urandom_range(0, 1);
      default: out_tready <= (stall_phase % 4 == 0);
    endcase
    stall_len--;
    stall_phase++;
  end

  // one cell beat; opens a new burst after a random gap when the old one runs out
  task automatic send_cell(input logic free, input logic last);
    int gap;
    if (burst_left == 0) begin
      // mostly short bursts, now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= lfsf_pkg::IN_DATA_W'(free);
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    cells_sent++;
    if (last) grids_sent++;
  endtask

  // small directed grid: bit i is the free flag of cell i
  task automatic send_pattern(input logic [15:0] free_bits, input int n);
    for (int i = 0; i < n; i++) send_cell(free_bits[i], i == n - 1);
  endtask

  task automatic send_random_grid(input int n, input int density);
    for (int i = 0; i < n; i++) send_cell($urandom_range(0, 99) < density, i == n - 1);
  endtask

  // hold the sender until every grid result is back and the pipe has drained
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // setup + access, then return to idle so calls can follow back to back
  task automatic apb_access(input logic wr, input logic [lfsf_pkg::APB_ADDR_W-1:0] addr,
                            input logic [lfsf_pkg::APB_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // write row_width with optional junk above bit 10, then read it back
  task automatic set_row_width(input logic [lfsf_pkg::CFG_W-1:0] w,
                               input logic [lfsf_pkg::APB_DATA_W-1:0] junk);
    wait_idle();
    apb_access(1'b1, ROW_WIDTH_ADDR,
               {junk[lfsf_pkg::APB_DATA_W-1:lfsf_pkg::CFG_W], w});
    apb_access(1'b0, ROW_WIDTH_ADDR, '0);
    eff_width = (w == 0) ? 1 :
                (w > lfsf_pkg::MAX_COLS_DEF) ? lfsf_pkg::MAX_COLS_DEF : int'(w);
    width_writes++;
  endtask

  initial begin
    int                              rows;
    int                              n;
    int                              density;
    logic [lfsf_pkg::CFG_W-1:0]      w;
    logic [lfsf_pkg::APB_DATA_W-1:0] junk;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single free cell at the reset width
    send_pattern(16'b1, 1);
    // width 0 acts as a single column; tie keeps the first square
    set_row_width(11'd0, '0);
    send_pattern(16'b1011, 4);
    // full 3x3 free square, then a grid of obstacles only
    set_row_width(11'd3, '0);
    send_pattern(16'h01ff, 9);
    send_pattern(16'h0000, 6);
    // write to the unmapped word must leave row_width alone; winner sits on row 0
    set_row_width(11'd2, '0);
    apb_access(1'b1, SPARE_ADDR, 32'hffff_ffff);
    apb_access(1'b0, ROW_WIDTH_ADDR, '0);
    send_pattern(16'b1110, 4);

    // one column, more rows than the line count: only cells past the row limit
    // are free, so nothing may win and the flag must be set
    set_row_width(11'd1, '0);
    for (int i = 0; i < 1026; i++) send_cell(i >= 1024, i == 1025);

    // random grids: mostly whole rows of dense content, some cut mid-row
    while (rand_cells < RAND_CELLS || rand_grids < RAND_GRIDS) begin
      if (rand_grids == 0 || $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 9))
          0:       w = 11'd0;
          1:       w = 11'd1;
          2:       w = 11'd1024;
          3:       w = $urandom_range(1025, 2047);
          default: w = $urandom_range(2, 12);
        endcase
        junk = ($urandom_range(0, 3) == 0) ? $urandom : '0;
        set_row_width(w, junk);
      end else if ($urandom_range(0, 7) == 0) begin
        wait_idle();
      end
      rows = $urandom_range(1, 9);
      n    = eff_width * rows;
      if (eff_width > 64) n = $urandom_range(1, 48);
      else if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      case ($urandom_range(0, 9))
        0:       density = 0;
        1:       density = 50;
        2, 3:    density = 100;
        4, 5, 6: density = 75;
        default: density = 90;
      endcase
      send_random_grid(n, density);
      rand_cells += n;
      rand_grids++;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("covered %0d cells in %0d grids over %0d row_width writes",
             cells_sent, grids_sent, width_writes);
    $display("incl. clamped widths and a grid running past the row limit");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
